[rtl/core/dfac_pkg.sv]
// shared types and constants for the dust frame average and calibrate block
package dfac_pkg;

  // frame layout
  localparam int unsigned SAMPLE_W   = 18;
  localparam int unsigned IDX_W      = 4;
  localparam logic [IDX_W-1:0] IDX_IDLE  = 4'd0;
  localparam logic [IDX_W-1:0] IDX_FIRST = 4'd1;
  localparam logic [IDX_W-1:0] IDX_WORD  = 4'd2;
  localparam logic [IDX_W-1:0] IDX_CHECK = 4'd8;

  // result widths
  localparam int unsigned READING_W = 21;
  localparam int unsigned OFFSET_W  = 24;
  localparam int unsigned BASE_W    = 16;

  // divide by ten through a reciprocal: magnitude below 2^24
  localparam int unsigned MAG_W     = 24;
  localparam int unsigned DIV10_SH  = 28;
  localparam int unsigned DIV10_MW  = 25;
  localparam logic [DIV10_MW-1:0] DIV10_M =
    DIV10_MW'(((64'd1 << DIV10_SH) + 64'd9) / 64'd10);
  localparam int unsigned QUOT_W    = 20;

  // saturation limits of the offset, at the width of the calibration sum
  localparam int unsigned CALSUM_W  = 26;
  localparam logic signed [CALSUM_W-1:0] OFFSET_MAX = 26'sd8388607;
  localparam logic signed [CALSUM_W-1:0] OFFSET_MIN = -26'sd8388608;

  // kind codes
  localparam logic KIND_BYTE  = 1'b0;
  localparam logic KIND_CALIB = 1'b1;

  // finished frame handed from the front to the back
  typedef struct packed {
    logic                ok;
    logic                cal;
    logic [SAMPLE_W-1:0] sample;
  } dfac_job_t;

  // one result beat
  typedef struct packed {
    logic                        frame_ok;
    logic signed [READING_W-1:0] reading;
    logic signed [OFFSET_W-1:0]  offset_now;
    logic                        calibrated;
  } dfac_res_t;

  // back end sequencer
  typedef enum logic [2:0] {
    B_IDLE,
    B_TOTAL,
    B_MUL1,
    B_OFS,
    B_MUL2,
    B_EMIT
  } dfac_bstate_t;

endpackage

[rtl/core/dfac_queue.sv]
// two-entry queue used between the stages of the block
module dfac_queue #(
  parameter int unsigned WIDTH = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop)      count <= count + 2'd1;
      else if (do_pop && !do_push) count <= count - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entry[wr_ptr] <= din;
  end

endmodule

[rtl/core/dfac_front.sv]
// byte parser: frame position, checksum, sample build and calibration flag
module dfac_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      take,
  input  logic                      kind,
  input  logic [7:0]                data_byte,
  input  logic                      frame_start,
  output logic                      job_push,
  output dfac_pkg::dfac_job_t       job
);
  import dfac_pkg::*;

  logic [IDX_W-1:0]    byte_index;
  logic [IDX_W-1:0]    byte_index_next;
  logic [7:0]          sum_acc;
  logic [7:0]          sum_acc_next;
  logic [SAMPLE_W-1:0] sample_acc;
  logic [SAMPLE_W-1:0] sample_acc_next;
  logic                calib_pending;
  logic                calib_pending_next;
  logic [7:0]          expect_sum;
  logic                sum_match;

  assign expect_sum = 8'd0 - sum_acc;
  assign sum_match  = (expect_sum == data_byte);

  // next state of the parser
  always_comb begin
    byte_index_next    = byte_index;
    sum_acc_next       = sum_acc;
    sample_acc_next    = sample_acc;
    calib_pending_next = calib_pending;
    job_push           = 1'b0;
    job.ok             = sum_match;
    job.cal            = sum_match && calib_pending;
    job.sample         = sample_acc;
    if (take) begin
      if (kind == KIND_CALIB) begin
        calib_pending_next = 1'b1;
      end else if (frame_start) begin
        byte_index_next = IDX_FIRST;
        sum_acc_next    = 8'd0;
        sample_acc_next = '0;
      end else if (byte_index == IDX_IDLE || byte_index > IDX_CHECK) begin
        byte_index_next = IDX_IDLE;
      end else if (byte_index < IDX_CHECK) begin
        sum_acc_next = sum_acc + data_byte;
        if (byte_index >= IDX_WORD) begin
          if (!byte_index[0]) sample_acc_next = sample_acc + {2'b0, data_byte, 8'd0};
          else                sample_acc_next = sample_acc + {10'd0, data_byte};
        end
        byte_index_next = byte_index + IDX_W'(1);
      end else begin
        // checksum byte closes the frame
        byte_index_next = IDX_IDLE;
        job_push        = 1'b1;
        if (sum_match) calib_pending_next = 1'b0;
      end
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= IDX_IDLE;
      sum_acc       <= 8'd0;
      sample_acc    <= '0;
      calib_pending <= 1'b0;
    end else begin
      byte_index    <= byte_index_next;
      sum_acc       <= sum_acc_next;
      sample_acc    <= sample_acc_next;
      calib_pending <= calib_pending_next;
    end
  end

endmodule

[rtl/core/dfac_back.sv]
// window average, offset correction, divide by ten and calibration
module dfac_back #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [15:0]               cfg_data,
  input  logic                      job_empty,
  input  dfac_pkg::dfac_job_t       job_in,
  output logic                      job_pop,
  input  logic                      res_full,
  output logic                      res_push,
  output dfac_pkg::dfac_res_t       res_out
);
  import dfac_pkg::*;

  // window sizing and reciprocal for the average
  localparam int unsigned LOG_N  = $clog2(WINDOW_LEN);
  localparam int unsigned PTR_W  = (WINDOW_LEN > 1) ? LOG_N : 1;
  localparam int unsigned TOT_W  = SAMPLE_W + LOG_N;
  localparam int unsigned AVG_SH = TOT_W + LOG_N;
  localparam int unsigned AVG_MW = TOT_W + 1;
  localparam logic [AVG_MW-1:0] AVG_M =
    AVG_MW'(((64'd1 << AVG_SH) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN));
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_LEN - 1);

  dfac_bstate_t state;
  dfac_bstate_t state_next;

  logic [BASE_W-1:0]          calib_base;
  dfac_job_t                  job_q;
  logic [SAMPLE_W-1:0]        window [WINDOW_LEN];
  logic [WINDOW_LEN-1:0]      window_valid;
  logic [PTR_W-1:0]           window_ptr;
  logic [TOT_W-1:0]           window_total;
  logic [SAMPLE_W-1:0]        old_raw;
  logic                       old_valid;
  logic [SAMPLE_W-1:0]        old_sample;
  logic [TOT_W+AVG_MW-1:0]    avg_prod;
  logic [SAMPLE_W-1:0]        avg;
  logic signed [MAG_W:0]      corr;
  logic                       corr_neg;
  logic [MAG_W-1:0]           corr_mag;
  logic [MAG_W+DIV10_MW-1:0]  div_prod;
  logic [QUOT_W-1:0]          quot;
  logic signed [READING_W-1:0] rd;
  logic signed [CALSUM_W-1:0] cal_sum;
  logic signed [OFFSET_W-1:0] cal_sat;
  logic signed [OFFSET_W-1:0] offset;
  logic                       do_cal;

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    res_push   = 1'b0;
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = job_in.ok ? B_TOTAL : B_EMIT;
        end
      end
      B_TOTAL: state_next = B_MUL1;
      B_MUL1:  state_next = B_OFS;
      B_OFS:   state_next = B_MUL2;
      B_MUL2:  state_next = B_EMIT;
      B_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // window memory with registered read of the oldest entry
  always_ff @(posedge clk) begin
    if (state == B_TOTAL) window[window_ptr] <= job_q.sample;
    old_raw <= window[window_ptr];
  end

  assign old_sample = old_valid ? old_raw : '0;

  // control registers: window bookkeeping, offset and base
  always_ff @(posedge clk) begin
    if (rst) begin
      window_valid <= '0;
      window_ptr   <= '0;
      window_total <= '0;
      old_valid    <= 1'b0;
      offset       <= '0;
      calib_base   <= '0;
    end else begin
      old_valid <= window_valid[window_ptr];
      if (cfg_write) calib_base <= cfg_data;
      if (state == B_TOTAL) begin
        window_total             <= window_total - TOT_W'(old_sample)
                                    + TOT_W'(job_q.sample);
        window_valid[window_ptr] <= 1'b1;
        window_ptr <= (window_ptr == PTR_LAST) ? '0 : window_ptr + PTR_W'(1);
      end
      if (do_cal) offset <= cal_sat;
    end
  end

  // arithmetic pipeline registers
  assign avg  = avg_prod[AVG_SH +: SAMPLE_W];
  assign corr = $signed({{(MAG_W + 1 - SAMPLE_W){1'b0}}, avg}) + {offset[OFFSET_W-1], offset};

  always_ff @(posedge clk) begin
    if (job_pop) job_q <= job_in;
    if (state == B_MUL1) avg_prod <= window_total * AVG_M;
    if (state == B_OFS) begin
      corr_neg <= corr[MAG_W];
      corr_mag <= corr[MAG_W] ? MAG_W'(-corr) : corr[MAG_W-1:0];
    end
    if (state == B_MUL2) div_prod <= corr_mag * DIV10_M;
  end

  // quotient sign, calibration sum and saturation
  assign quot    = div_prod[DIV10_SH +: QUOT_W];
  assign rd      = corr_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign cal_sum = {{(CALSUM_W - OFFSET_W){offset[OFFSET_W-1]}}, offset}
                   + $signed({{(CALSUM_W - BASE_W){1'b0}}, calib_base})
                   - {{(CALSUM_W - READING_W){rd[READING_W-1]}}, rd};

  always_comb begin
    if (cal_sum > OFFSET_MAX)      cal_sat = OFFSET_MAX[OFFSET_W-1:0];
    else if (cal_sum < OFFSET_MIN) cal_sat = OFFSET_MIN[OFFSET_W-1:0];
    else                           cal_sat = cal_sum[OFFSET_W-1:0];
  end

  assign do_cal = res_push && job_q.ok && job_q.cal;

  // result beat
  always_comb begin
    res_out.frame_ok   = job_q.ok;
    res_out.reading    = job_q.ok ? rd : '0;
    res_out.offset_now = do_cal ? cal_sat : offset;
    res_out.calibrated = job_q.ok && job_q.cal;
  end

endmodule

[rtl/core/dust_frame_average_calibrate.sv]
// top level of the dust frame checker with window average and calibration
//
// Input channel: push with kind, data_byte and frame_start; a beat is taken
// when push is high and full is low. One beat per cycle is sustained: the
// parser handles each byte in the cycle it arrives, and full only rises
// when two finished frames are still queued for the arithmetic back end.
// Result channel: empty and pop; the oldest result sits on frame_ok,
// reading, offset_now and calibrated while empty is low, and leaves on pop.
// One result appears for each checksum byte once the back end is free; a
// bad checksum goes straight to the result, and a good frame passes
// through a window update, two registered multiplies for the average and
// the divide by ten, and the calibration sum, well inside the nine beats
// of a frame.
// A stalled receiver fills the two-entry result queue, then the two-entry
// frame queue, then full rises; nothing is dropped.
// calib_base is written through cfg_write and cfg_data.
// Reset clears the frame parser, the window (through per-entry valid bits),
// the offset, the pending calibration and both queues; the block takes
// beats from the first cycle after reset.
module dust_frame_average_calibrate #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        kind,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        empty,
  input  logic        pop,
  output logic        frame_ok,
  output logic signed [20:0] reading,
  output logic signed [23:0] offset_now,
  output logic        calibrated
);
  import dfac_pkg::*;

  localparam int unsigned JOB_W = $bits(dfac_job_t);
  localparam int unsigned RES_W = $bits(dfac_res_t);

  logic      take;
  logic      job_push;
  dfac_job_t job_wr;
  dfac_job_t job_rd;
  logic      job_full;
  logic      job_empty;
  logic      job_pop;
  logic      res_push;
  logic      res_full;
  dfac_res_t res_wr;
  dfac_res_t res_rd;

  assign full = job_full;
  assign take = push && !job_full;

  // byte parser
  dfac_front u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .kind        (kind),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .job_push    (job_push),
    .job         (job_wr)
  );

  // finished frames waiting for the back end
  dfac_queue #(.WIDTH(JOB_W)) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_wr),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_rd),
    .empty (job_empty)
  );

  // arithmetic back end
  dfac_back #(.WINDOW_LEN(WINDOW_LEN)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .job_empty (job_empty),
    .job_in    (job_rd),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_out   (res_wr)
  );

  // result queue facing the receiver
  dfac_queue #(.WIDTH(RES_W)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_wr),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_rd),
    .empty (empty)
  );

  assign frame_ok   = res_rd.frame_ok;
  assign reading    = res_rd.reading;
  assign offset_now = res_rd.offset_now;
  assign calibrated = res_rd.calibrated;

endmodule

[rtl/core/dfac_checker.sv]
// port-level checks of the dust frame block, bound to the top level
module dfac_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        frame_ok,
  input logic signed [20:0] reading,
  input logic signed [23:0] offset_now,
  input logic        calibrated
);

  // both queues come out of reset empty
  a_reset_clear: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not clear after reset");

  // a bad checksum gives a zero reading and never calibrates
  a_bad_frame: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_ok) |-> (reading == 21'sd0 && !calibrated))
    else $error("bad frame carries a reading or calibration");

  // a result beat that is not taken stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(reading) && $stable(offset_now)
                          && $stable(frame_ok) && $stable(calibrated)))
    else $error("waiting result beat changed");

  // offset moves only on a beat that reports calibration
  a_offset_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) ##1 (!empty && !calibrated) |-> (offset_now == $past(offset_now)))
    else $error("offset changed without calibration");

endmodule

bind dust_frame_average_calibrate dfac_checker u_dfac_checker (.*);
